@@ src/pfl_pkg.sv @@
// pfl_pkg: shared constants, codes and item types of the page free-list allocator.
// Depends on nothing; pfl_ctrl and the top refer to it by scoped names.
package pfl_pkg;

  localparam int unsigned MAX_PAGES  = 131072;
  localparam int unsigned PAGE_BYTES = 4096;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned OFS_W  = $clog2(PAGE_BYTES);
  localparam int unsigned PN_W   = ADDR_W - OFS_W;          // page number width
  localparam int unsigned IDX_W  = $clog2(MAX_PAGES);       // stack address width
  localparam int unsigned CNT_W  = $clog2(MAX_PAGES + 1);   // fill count width

  localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_PAGES);
  localparam logic [PN_W:0]    MAX_PN_EXT = (PN_W + 1)'(MAX_PAGES);

  // operation codes carried in the kind field
  localparam int unsigned KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_REBUILD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd2;

  // configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIMIT  = 1'b1;
  localparam logic [ADDR_W-1:0] KERNEL_END_RESET = 32'h4000_0000;
  localparam logic [ADDR_W-1:0] MEM_LIMIT_RESET  = 32'h6000_0000;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OOM      = 3'd1,
    ST_BAD_ADDR = 3'd2,
    ST_FULL     = 3'd3,
    ST_TRUNC    = 3'd4
  } pfl_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_RB_SIZE,
    S_RB_FILL
  } pfl_state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] release_address;
  } pfl_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    pfl_status_e       status;
    logic [CNT_W-1:0]  pages_free;
  } pfl_rsp_t;

  // one access to the stack memory
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    logic [PN_W-1:0]  wdata;
  } pfl_mem_req_t;

endpackage

@@ src/pfl_stack_ram.sv @@
// pfl_stack_ram: generic single-port synchronous RAM, one access per cycle,
// registered read data. No dependencies.
module pfl_stack_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pfl_ctrl.sv @@
// pfl_ctrl: sequencer of the free list: fill count, rebuild walk, pop and push.
// Depends on pfl_pkg; drives the stack RAM through a pfl_mem_req_t.
module pfl_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  pfl_pkg::pfl_req_t            req_i,
  input  logic [pfl_pkg::ADDR_W-1:0]   kernel_end_i,
  input  logic [pfl_pkg::ADDR_W-1:0]   mem_limit_i,
  output pfl_pkg::pfl_mem_req_t        mem_o,
  input  logic [pfl_pkg::PN_W-1:0]     mem_rdata_i,
  output logic                         done_o,
  output pfl_pkg::pfl_rsp_t            rsp_o
);

  pfl_pkg::pfl_state_e state_q, state_d;

  logic [pfl_pkg::CNT_W-1:0] total_q, total_d;
  logic [pfl_pkg::CNT_W-1:0] idx_q, idx_d;
  logic [pfl_pkg::CNT_W-1:0] target_q, target_d;
  logic                      trunc_q, trunc_d;
  logic [pfl_pkg::PN_W:0]    pn_q, pn_d;
  logic                      done_q, done_d;
  pfl_pkg::pfl_rsp_t         rsp_q, rsp_d;

  logic                      accept;
  logic [pfl_pkg::PN_W:0]    start_pn;
  logic [pfl_pkg::PN_W:0]    lim_pn;
  logic [pfl_pkg::PN_W:0]    span;
  logic [pfl_pkg::CNT_W-1:0] total_dec;
  logic [pfl_pkg::CNT_W-1:0] total_inc;
  logic                      bad_addr;

  assign accept    = start && (state_q == pfl_pkg::S_IDLE);
  // round the kernel end up to a page boundary, kept one bit wider to avoid wrap
  assign start_pn  = {1'b0, kernel_end_i[pfl_pkg::ADDR_W-1:pfl_pkg::OFS_W]}
                   + (pfl_pkg::PN_W + 1)'(kernel_end_i[pfl_pkg::OFS_W-1:0] != '0);
  assign lim_pn    = {1'b0, mem_limit_i[pfl_pkg::ADDR_W-1:pfl_pkg::OFS_W]};
  assign span      = lim_pn - pn_q;
  assign total_dec = total_q - 1'b1;
  assign total_inc = total_q + 1'b1;
  assign bad_addr  = (req_i.release_address == '0)
                  || (req_i.release_address[pfl_pkg::OFS_W-1:0] != '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfl_pkg::S_IDLE: begin
        if (start) begin
          if (req_i.kind == pfl_pkg::KIND_REBUILD) begin
            state_d = pfl_pkg::S_RB_SIZE;
          end else if (req_i.kind == pfl_pkg::KIND_ALLOC && total_q != '0) begin
            state_d = pfl_pkg::S_ALLOC_RD;
          end
        end
      end
      pfl_pkg::S_ALLOC_RD: state_d = pfl_pkg::S_IDLE;
      pfl_pkg::S_RB_SIZE:  state_d = pfl_pkg::S_RB_FILL;
      pfl_pkg::S_RB_FILL: begin
        if (idx_q == target_q) begin
          state_d = pfl_pkg::S_IDLE;
        end
      end
      default: state_d = pfl_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    mem_o    = '0;
    total_d  = total_q;
    idx_d    = idx_q;
    target_d = target_q;
    trunc_d  = trunc_q;
    pn_d     = pn_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    unique case (state_q)
      pfl_pkg::S_IDLE: begin
        if (accept) begin
          case (req_i.kind)
            pfl_pkg::KIND_REBUILD: begin
              pn_d = start_pn;
            end
            pfl_pkg::KIND_ALLOC: begin
              if (total_q == '0) begin
                done_d = 1'b1;
                rsp_d  = '{page_address: '0, status: pfl_pkg::ST_OOM, pages_free: total_q};
              end else begin
                mem_o.re   = 1'b1;
                mem_o.addr = total_dec[pfl_pkg::IDX_W-1:0];
                total_d    = total_dec;
              end
            end
            pfl_pkg::KIND_FREE: begin
              done_d = 1'b1;
              if (bad_addr) begin
                rsp_d = '{page_address: '0, status: pfl_pkg::ST_BAD_ADDR,
                          pages_free: total_q};
              end else if (total_q >= pfl_pkg::MAX_CNT) begin
                rsp_d = '{page_address: '0, status: pfl_pkg::ST_FULL, pages_free: total_q};
              end else begin
                mem_o.we    = 1'b1;
                mem_o.addr  = total_q[pfl_pkg::IDX_W-1:0];
                mem_o.wdata = req_i.release_address[pfl_pkg::ADDR_W-1:pfl_pkg::OFS_W];
                total_d     = total_inc;
                rsp_d = '{page_address: '0, status: pfl_pkg::ST_OK, pages_free: total_inc};
              end
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = '{page_address: '0, status: pfl_pkg::ST_OK, pages_free: total_q};
            end
          endcase
        end
      end
      pfl_pkg::S_ALLOC_RD: begin
        done_d = 1'b1;
        rsp_d  = '{page_address: {mem_rdata_i, {pfl_pkg::OFS_W{1'b0}}},
                   status: pfl_pkg::ST_OK, pages_free: total_q};
      end
      pfl_pkg::S_RB_SIZE: begin
        idx_d   = '0;
        trunc_d = 1'b0;
        if (pn_q >= lim_pn) begin
          target_d = '0;
        end else if (span > pfl_pkg::MAX_PN_EXT) begin
          target_d = pfl_pkg::MAX_CNT;
          trunc_d  = 1'b1;
        end else begin
          target_d = span[pfl_pkg::CNT_W-1:0];
        end
      end
      pfl_pkg::S_RB_FILL: begin
        if (idx_q == target_q) begin
          total_d = target_q;
          done_d  = 1'b1;
          rsp_d   = '{page_address: '0,
                      status: trunc_q ? pfl_pkg::ST_TRUNC : pfl_pkg::ST_OK,
                      pages_free: target_q};
        end else begin
          // ascending page numbers from the bottom of the stack
          mem_o.we    = 1'b1;
          mem_o.addr  = idx_q[pfl_pkg::IDX_W-1:0];
          mem_o.wdata = pn_q[pfl_pkg::PN_W-1:0];
          pn_d        = pn_q + 1'b1;
          idx_d       = idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfl_pkg::S_IDLE;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    target_q <= target_d;
    trunc_q  <= trunc_d;
    pn_q     <= pn_d;
    rsp_q    <= rsp_d;
  end

  assign busy   = (state_q != pfl_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ src/page_free_list_allocator_top.sv @@
// page_free_list_allocator_top: configuration registers, sequencer and stack RAM.
// Depends on pfl_pkg, pfl_ctrl and pfl_stack_ram.
//
//  port group                       dir  handshake
//  start / req_i                    in   taken at a clock edge with start high, busy low
//  done_o / rsp_o                   out  one-cycle strobe, no back-pressure
//  cfg_we_i / cfg_idx_i / cfg_wdata_i  in  written at any edge with cfg_we_i high
//
// Free, no-op and empty-list allocate items end in S_IDLE; allocate adds a RAM read state.
// Rebuild runs S_RB_SIZE, then S_RB_FILL with one RAM write per page pushed.
// The result strobe is registered: it comes in the cycle after the item's last state.
// After reset the list is empty; stack contents are undefined and need no clearing pass.
// The receiver cannot stall results; busy holds off new items during multi-cycle work.
module page_free_list_allocator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  pfl_pkg::pfl_req_t                req_i,
  output logic                             done_o,
  output pfl_pkg::pfl_rsp_t                rsp_o,
  input  logic                             cfg_we_i,
  input  logic [pfl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pfl_pkg::ADDR_W-1:0]       cfg_wdata_i
);

  logic [pfl_pkg::ADDR_W-1:0] kernel_end_q, kernel_end_d;
  logic [pfl_pkg::ADDR_W-1:0] mem_limit_q, mem_limit_d;
  pfl_pkg::pfl_mem_req_t      mem_req;
  logic [pfl_pkg::PN_W-1:0]   mem_rdata;

  always_comb begin
    kernel_end_d = kernel_end_q;
    mem_limit_d  = mem_limit_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfl_pkg::CFG_KERNEL_END: kernel_end_d = cfg_wdata_i;
        pfl_pkg::CFG_MEM_LIMIT:  mem_limit_d  = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_end_q <= pfl_pkg::KERNEL_END_RESET;
      mem_limit_q  <= pfl_pkg::MEM_LIMIT_RESET;
    end else begin
      kernel_end_q <= kernel_end_d;
      mem_limit_q  <= mem_limit_d;
    end
  end

  pfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .kernel_end_i(kernel_end_q),
    .mem_limit_i (mem_limit_q),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  pfl_stack_ram #(
    .DEPTH(pfl_pkg::MAX_PAGES),
    .WIDTH(pfl_pkg::PN_W)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .re_i   (mem_req.re),
    .addr_i (mem_req.addr),
    .wdata_i(mem_req.wdata),
    .rdata_o(mem_rdata)
  );

`ifndef SYNTH
  // a result always lands with the sequencer back at idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // a taken free item raises the result strobe in the cycle after it is taken
  a_free_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.kind == pfl_pkg::KIND_FREE) |=> done_o)
    else $error("free item did not finish in one cycle");

  // out of memory means nothing handed out and an empty list
  a_oom_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == pfl_pkg::ST_OOM) |->
      (rsp_o.page_address == '0 && rsp_o.pages_free == '0))
    else $error("out of memory with pages left");

  // the count never passes the stack depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.pages_free <= pfl_pkg::MAX_CNT)
    else $error("free count above stack depth");
`endif

endmodule
